// ===== hw/rtl/irc_lft_pkg.sv =====
// Package for the chat-protocol line field tagger.
// Holds the result item type, field tags, line status codes and queue sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irc_lft_pkg;

   localparam int MaxParams  = 15;
   localparam int CountW     = 5;
   localparam int QueueDepth = 2;   // power of two
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCountW    = $clog2(QueueDepth + 1);

   localparam logic [7:0] ByteCr    = 8'h0D;
   localparam logic [7:0] ByteLf    = 8'h0A;
   localparam logic [7:0] ByteColon = 8'h3A;
   localparam logic [7:0] ByteSpace = 8'h20;

   localparam logic [2:0] TagSep     = 3'd0;
   localparam logic [2:0] TagOrigin  = 3'd1;
   localparam logic [2:0] TagCommand = 3'd2;
   localparam logic [2:0] TagParam   = 3'd3;
   localparam logic [2:0] TagDropped = 3'd4;
   localparam logic [2:0] TagBody    = 3'd5;
   localparam logic [2:0] TagEnd     = 3'd6;

   localparam logic [1:0] StatusEmpty   = 2'd0;
   localparam logic [1:0] StatusValid   = 2'd1;
   localparam logic [1:0] StatusInvalid = 2'd2;

   typedef struct packed {
      logic [1:0] line_status;
      logic       token_first;
      logic [3:0] param_index;
      logic [2:0] field_tag;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/irc_lft_front.sv =====
// Front end: accepts bytes, tracks line state and classifies each byte.
// Uses irc_lft_pkg; pushes one result item per byte into the queue.
`timescale 1ns / 1ps
`default_nettype none

module irc_lft_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [7:0]               req_tdata,    // data_byte
   input  wire                      queue_full,
   output logic                     push,
   output irc_lft_pkg::result_type  push_item
);

   logic                           at_line_start_ff, at_line_start_in;
   logic                           prefix_colon_ff, prefix_colon_in;
   logic                           in_body_ff, in_body_in;
   logic                           in_token_ff, in_token_in;
   logic [irc_lft_pkg::CountW-1:0] token_count_ff, token_count_in;
   logic                           line_has_bytes_ff, line_has_bytes_in;
   logic [irc_lft_pkg::CountW-1:0] class_count;

   localparam logic [irc_lft_pkg::CountW-1:0] CountOne =
      irc_lft_pkg::CountW'(1);
   localparam logic [irc_lft_pkg::CountW-1:0] CountLastParam =
      irc_lft_pkg::CountW'(irc_lft_pkg::MaxParams + 1);
   localparam logic [irc_lft_pkg::CountW-1:0] CountSat =
      irc_lft_pkg::CountW'(irc_lft_pkg::MaxParams + 2);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      at_line_start_in  = at_line_start_ff;
      prefix_colon_in   = prefix_colon_ff;
      in_body_in        = in_body_ff;
      in_token_in       = in_token_ff;
      token_count_in    = token_count_ff;
      line_has_bytes_in = line_has_bytes_ff;
      push_item             = '0;
      push_item.field_tag   = irc_lft_pkg::TagSep;
      push_item.line_status = irc_lft_pkg::StatusEmpty;
      class_count           = token_count_ff;

      if (req_tdata == irc_lft_pkg::ByteCr || req_tdata == irc_lft_pkg::ByteLf) begin
         push_item.field_tag = irc_lft_pkg::TagEnd;
         if (!line_has_bytes_ff) begin
            push_item.line_status = irc_lft_pkg::StatusEmpty;
         end else if (token_count_ff >= CountOne) begin
            push_item.line_status = irc_lft_pkg::StatusValid;
         end else begin
            push_item.line_status = irc_lft_pkg::StatusInvalid;
         end
         at_line_start_in  = 1'b1;
         prefix_colon_in   = 1'b0;
         in_body_in        = 1'b0;
         in_token_in       = 1'b0;
         token_count_in    = '0;
         line_has_bytes_in = 1'b0;
      end else begin
         if (in_body_ff) begin
            push_item.field_tag   = irc_lft_pkg::TagBody;
            push_item.token_first = !in_token_ff;
            in_token_in           = 1'b1;
         end else if (req_tdata == irc_lft_pkg::ByteColon) begin
            if (at_line_start_ff) begin
               push_item.field_tag   = irc_lft_pkg::TagOrigin;
               push_item.token_first = 1'b1;
               prefix_colon_in       = 1'b1;
               in_token_in           = 1'b1;
            end else begin
               in_body_in      = 1'b1;
               in_token_in     = 1'b0;
               prefix_colon_in = 1'b0;
            end
         end else if (req_tdata == irc_lft_pkg::ByteSpace) begin
            in_token_in     = 1'b0;
            prefix_colon_in = 1'b0;
         end else if (in_token_ff && prefix_colon_ff) begin
            push_item.field_tag = irc_lft_pkg::TagOrigin;
         end else begin
            if (!in_token_ff) begin
               in_token_in           = 1'b1;
               push_item.token_first = 1'b1;
               if (token_count_ff < CountSat) begin
                  token_count_in = token_count_ff + CountOne;
               end
               class_count = token_count_in;
            end
            if (class_count <= CountOne) begin
               push_item.field_tag = irc_lft_pkg::TagCommand;
            end else if (class_count <= CountLastParam) begin
               push_item.field_tag   = irc_lft_pkg::TagParam;
               push_item.param_index = 4'(class_count - CountOne);
            end else begin
               push_item.field_tag = irc_lft_pkg::TagDropped;
            end
         end
         at_line_start_in  = 1'b0;
         line_has_bytes_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff  <= 1'b1;
         prefix_colon_ff   <= 1'b0;
         in_body_ff        <= 1'b0;
         in_token_ff       <= 1'b0;
         token_count_ff    <= '0;
         line_has_bytes_ff <= 1'b0;
      end else if (push) begin
         at_line_start_ff  <= at_line_start_in;
         prefix_colon_ff   <= prefix_colon_in;
         in_body_ff        <= in_body_in;
         in_token_ff       <= in_token_in;
         token_count_ff    <= token_count_in;
         line_has_bytes_ff <= line_has_bytes_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/irc_lft_queue.sv =====
// Short result queue between the front end and the output stage.
// Uses irc_lft_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module irc_lft_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  irc_lft_pkg::result_type  push_item,
   output logic                     full,
   input  wire                      pop,
   output logic                     not_empty,
   output irc_lft_pkg::result_type  pop_item
);

   irc_lft_pkg::result_type           mem [irc_lft_pkg::QueueDepth];
   logic [irc_lft_pkg::QPtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [irc_lft_pkg::QCountW-1:0]   count_ff, count_in;

   assign full      = count_ff == irc_lft_pkg::QCountW'(irc_lft_pkg::QueueDepth);
   assign not_empty = count_ff != '0;
   assign pop_item  = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + irc_lft_pkg::QCountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - irc_lft_pkg::QCountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + irc_lft_pkg::QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + irc_lft_pkg::QPtrW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/irc_lft_back.sv =====
// Output stage: registers result items from the queue onto the result stream.
// Uses irc_lft_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module irc_lft_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      queue_not_empty,
   input  irc_lft_pkg::result_type  queue_item,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [15:0]              rsp_tdata   // field_tag, param_index, token_first,
                                                // line_status, zero pad
);

   logic                     valid_ff;
   irc_lft_pkg::result_type  item_ff;

   assign pop        = queue_not_empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, item_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_tready) begin
         valid_ff <= queue_not_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= queue_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/irc_line_field_tagger_top.sv =====
// Top level of the chat-protocol line field tagger.
// Instantiates irc_lft_front, irc_lft_queue and irc_lft_back; uses irc_lft_pkg.
//
// Usage:
//   req_*: raw stream bytes, one per item, in tdata[7:0].
//   rsp_*: one result item per byte, in order: tdata[2:0] field tag,
//          [6:3] parameter index, [7] first byte of token or body,
//          [9:8] line status (meaningful on line-end bytes), [15:10] zero.
//   An accepted byte is written into the queue, then moved into the output
//   register, from which rsp shows it until the receiver takes it.
//   Throughput: one byte per cycle while the queue is not full, with the line
//   state in the front end updated as each byte is accepted.
//   A two-entry queue sits between front end and output register, so the
//   front end keeps accepting while a result waits; req_tready drops only
//   when the queue is full, i.e. in the cycle after the receiver stalls while
//   items stream back to back.
//   Reset (synchronous, active high) empties the queue and output register
//   and returns the line state to the start of a fresh line.
`timescale 1ns / 1ps
`default_nettype none

module irc_line_field_tagger_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,    // data_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [15:0]  rsp_tdata     // field_tag, param_index, token_first,
                                      // line_status, zero pad
);

   logic                     push, pop, queue_full, queue_not_empty;
   irc_lft_pkg::result_type  push_item, pop_item;

   irc_lft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   irc_lft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   irc_lft_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_item      (pop_item),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/irc_lft_checker.sv =====
// Port-level checks for the line field tagger, bound to the top level.
// Uses irc_lft_pkg for tag and status codes.
`timescale 1ns / 1ps
`default_nettype none

module irc_lft_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [15:0]  rsp_tdata
);

   logic [2:0] tag;
   assign tag = rsp_tdata[2:0];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && tag != irc_lft_pkg::TagEnd |-> rsp_tdata[9:8] == irc_lft_pkg::StatusEmpty)
      else $error("line status on a byte that is not a line end");

   a_index_only_param: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && tag != irc_lft_pkg::TagParam |-> rsp_tdata[6:3] == 4'd0)
      else $error("parameter index outside a parameter");

   a_end_not_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (tag == irc_lft_pkg::TagEnd || tag == irc_lft_pkg::TagSep)
      |-> !rsp_tdata[7])
      else $error("token start flagged on a separator or line end");

endmodule

bind irc_line_field_tagger_top irc_lft_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
